/* rtl/length_prefixed_packet_deframer_assert.svh */
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LPPD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define LPPD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

/* rtl/lppd_pkg.sv */
// Package with the shared constants and types of the packet deframer.
`default_nettype none
package lppd_pkg;

  localparam int HDR_BYTES = 8;
  localparam int HDR_IDX_W = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;
  localparam int LEN_W = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd29000;

  typedef enum logic [1:0] {
    CMD_BODY = 2'd0,
    CMD_DROP = 2'd1,
    CMD_HDR  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [7:0]                  data;
    logic                        last;
    logic [HDR_BYTES-1:0][7:0]   hdr;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/lppd_if.sv */
// Handshake interfaces for the byte input, the result output and the configuration write.
`default_nettype none
interface lppd_rx_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface lppd_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_in_packet;
  logic       header_dropped;
  modport source (output valid, out_byte, last_in_packet, header_dropped, input ready);
  modport sink (input valid, out_byte, last_in_packet, header_dropped, output ready);
endinterface

interface lppd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/lppd_queue.sv */
// Small command queue between the deframer front and back ends.
`default_nettype none
module lppd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lppd_pkg::cmd_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output lppd_pkg::cmd_t       pop_data,
  output logic                 empty
);

  lppd_pkg::cmd_t                  entries [lppd_pkg::QUEUE_DEPTH];
  logic [lppd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [lppd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [lppd_pkg::QPTR_W:0]       count;

  assign full     = (count == (lppd_pkg::QPTR_W+1)'(lppd_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lppd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lppd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (lppd_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (lppd_pkg::QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/lppd_front.sv */
// Front end: gathers headers, checks the packet length and tracks the body.
`default_nettype none
module lppd_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  lppd_rx_if.sink                        rx,
  input  wire logic [lppd_pkg::LEN_W-1:0] max_len,
  input  wire logic                      q_full,
  output logic                           push,
  output lppd_pkg::cmd_t                 cmd
);

  logic                                    in_body;
  logic [lppd_pkg::HDR_IDX_W-1:0]          hdr_count;
  logic [lppd_pkg::LEN_W-1:0]              body_rem;
  logic [lppd_pkg::HDR_BYTES-1:0][7:0]     hdr_store;

  logic [lppd_pkg::HDR_BYTES-1:0][7:0]     hdr_cur;
  logic [lppd_pkg::LEN_W-1:0]              pkt_len;
  logic [lppd_pkg::LEN_W-1:0]              rem_dec;
  logic                                    hdr_done;
  logic                                    len_bad;
  logic                                    hdr_only;
  logic                                    accept;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    hdr_cur = hdr_store;
    hdr_cur[hdr_count] = rx.data_byte;
  end

  assign pkt_len  = {hdr_cur[0], hdr_cur[1]};
  assign hdr_done = (hdr_count == lppd_pkg::HDR_IDX_W'(lppd_pkg::HDR_BYTES - 1));
  assign len_bad  = (pkt_len < lppd_pkg::LEN_W'(lppd_pkg::HDR_BYTES)) || (pkt_len > max_len);
  assign hdr_only = (pkt_len == lppd_pkg::LEN_W'(lppd_pkg::HDR_BYTES));
  assign rem_dec  = (body_rem != '0) ? body_rem - lppd_pkg::LEN_W'(1) : '0;

  assign push = accept && !rx.func && (in_body || hdr_done);

  always_comb begin
    cmd.data = rx.data_byte;
    cmd.hdr  = hdr_cur;
    if (in_body) begin
      cmd.kind = lppd_pkg::CMD_BODY;
      cmd.last = (rem_dec == '0);
    end else begin
      cmd.kind = len_bad ? lppd_pkg::CMD_DROP : lppd_pkg::CMD_HDR;
      cmd.last = hdr_only;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body   <= 1'b0;
      hdr_count <= '0;
      body_rem  <= '0;
    end else if (accept) begin
      if (rx.func) begin
        in_body   <= 1'b0;
        hdr_count <= '0;
        body_rem  <= '0;
      end else if (in_body) begin
        body_rem <= rem_dec;
        if (rem_dec == '0) begin
          in_body <= 1'b0;
        end
      end else begin
        hdr_count <= hdr_done ? '0 : hdr_count + lppd_pkg::HDR_IDX_W'(1);
        if (hdr_done && !len_bad && !hdr_only) begin
          in_body  <= 1'b1;
          body_rem <= pkt_len - lppd_pkg::LEN_W'(lppd_pkg::HDR_BYTES);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !rx.func && !in_body) begin
      hdr_store[hdr_count] <= rx.data_byte;
    end
  end

endmodule
`default_nettype wire

/* rtl/lppd_back.sv */
// Back end: turns queued commands into output beats through an output register.
`default_nettype none
module lppd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire lppd_pkg::cmd_t  q_data,
  output logic                 pop,
  lppd_pkt_if.source           pkt
);

  logic                              busy;
  lppd_pkg::cmd_t                    cur;
  logic [lppd_pkg::HDR_IDX_W-1:0]    idx;

  logic                              out_load;
  logic                              adv;
  logic                              done;
  logic [7:0]                        beat_byte;
  logic                              beat_last;
  logic                              beat_drop;

  assign out_load = !pkt.valid || pkt.ready;
  assign adv      = busy && out_load;
  assign done     = (cur.kind != lppd_pkg::CMD_HDR) ||
                    (idx == lppd_pkg::HDR_IDX_W'(lppd_pkg::HDR_BYTES - 1));
  assign pop      = !q_empty && (!busy || (adv && done));

  always_comb begin
    unique case (cur.kind)
      lppd_pkg::CMD_BODY: begin
        beat_byte = cur.data;
        beat_last = cur.last;
        beat_drop = 1'b0;
      end
      lppd_pkg::CMD_HDR: begin
        beat_byte = cur.hdr[idx];
        beat_last = cur.last && done;
        beat_drop = 1'b0;
      end
      default: begin
        beat_byte = 8'd0;
        beat_last = 1'b0;
        beat_drop = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      pkt.valid <= 1'b0;
    end else begin
      if (out_load) begin
        pkt.valid <= adv;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        if (done) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + lppd_pkg::HDR_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pkt.out_byte       <= beat_byte;
      pkt.last_in_packet <= beat_last;
      pkt.header_dropped <= beat_drop;
    end
  end

endmodule
`default_nettype wire

/* rtl/length_prefixed_packet_deframer.sv */
// Top level of the length-prefixed packet deframer.
// The block takes one beat per cycle on rx and gives at most one beat per cycle on pkt.
// A data byte that completes an 8-byte header releases the whole header as 8 output
// beats, or one drop beat if its length is out of range; a body byte gives one. Those
// bursts and any output stall are absorbed by a 4-entry command queue between the
// header/length front end and the beat-emitting back end, and rx stalls only when that
// queue is full. An accepted byte passes the queue entry and the back-end command register
// before the output register. The maximum packet length register resets to 29000 and
// is written through cfg, which is always ready.
`default_nettype none
module length_prefixed_packet_deframer (
  input  wire logic   clk,
  input  wire logic   rst,
  lppd_rx_if.sink     rx,
  lppd_pkt_if.source  pkt,
  lppd_cfg_if.sink    cfg
);

  logic [lppd_pkg::LEN_W-1:0] max_len;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  lppd_pkg::cmd_t             push_cmd;
  lppd_pkg::cmd_t             head_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lppd_pkg::MAX_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_len <= cfg.data;
    end
  end

  lppd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .max_len (max_len),
    .q_full  (q_full),
    .push    (q_push),
    .cmd     (push_cmd)
  );

  lppd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  lppd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (head_cmd),
    .pop     (q_pop),
    .pkt     (pkt)
  );

endmodule
`default_nettype wire

/* rtl/lppd_checker.sv */
// Port-level checker for the packet deframer and its bind to the top level.
`default_nettype none
`include "length_prefixed_packet_deframer_assert.svh"
module lppd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_ready,
  input wire logic       pkt_valid,
  input wire logic       pkt_ready,
  input wire logic [7:0] pkt_byte,
  input wire logic       pkt_last,
  input wire logic       pkt_drop
);

  `LPPD_ASSERT_NXT(a_stall_hold, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt_byte) && $stable(pkt_last) && $stable(pkt_drop))
  `LPPD_ASSERT_IMP(a_drop_beat_shape, pkt_valid && pkt_drop, (pkt_byte == 8'd0) && !pkt_last)
  `LPPD_ASSERT_IMP(a_no_beat_after_reset, $fell(rst), !pkt_valid)
  `LPPD_ASSERT_IMP(a_ready_after_reset, $fell(rst), rx_ready)

endmodule

bind length_prefixed_packet_deframer lppd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .pkt_valid (pkt.valid),
  .pkt_ready (pkt.ready),
  .pkt_byte  (pkt.out_byte),
  .pkt_last  (pkt.last_in_packet),
  .pkt_drop  (pkt.header_dropped)
);
`default_nettype wire

/* sim/tb_length_prefixed_packet_deframer.sv */
`timescale 1ns / 1ps
// Testbench that checks the packet deframer beat by beat against a model of its framing rules.
module tb_length_prefixed_packet_deframer;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;
  localparam int RANDOM_ITEMS = 70;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       dropped;
  } pkt_beat_t;

  typedef enum int {RCV_STREAM, RCV_COIN, RCV_SPARSE, RCV_PERIODIC} rcv_mode_t;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  lppd_rx_if  rx();
  lppd_pkt_if pkt();
  lppd_cfg_if cfg();

  length_prefixed_packet_deframer dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .pkt(pkt),
    .cfg(cfg)
  );

  logic [lppd_pkg::LEN_W-1:0] max_len = lppd_pkg::MAX_LEN_RESET;
  bit                         in_body = 1'b0;
  logic [7:0]                 hdr_bytes [lppd_pkg::HDR_BYTES];
  int                         hdr_count = 0;
  logic [lppd_pkg::LEN_W-1:0] body_left = '0;
  pkt_beat_t                  pkt_expected [$];

  int        fail_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        hold_request = 0;
  int        hold_left = 0;
  int        rcv_cycle = 0;
  rcv_mode_t rcv_mode = RCV_STREAM;

  task automatic deframe_byte(input logic is_close, input logic [7:0] b);
    logic [lppd_pkg::LEN_W-1:0] len;
    bit last_beat;
    if (is_close) begin
      in_body = 1'b0;
      hdr_count = 0;
      body_left = '0;
    end else if (in_body) begin
      if (body_left != 0) body_left = body_left - 1'b1;
      last_beat = (body_left == 0);
      if (last_beat) begin
        in_body = 1'b0;
        hdr_count = 0;
      end
      pkt_expected.push_back('{b, last_beat, 1'b0});
    end else begin
      hdr_bytes[hdr_count] = b;
      hdr_count++;
      if (hdr_count == lppd_pkg::HDR_BYTES) begin
        hdr_count = 0;
        len = {hdr_bytes[0], hdr_bytes[1]};
        if (len < lppd_pkg::HDR_BYTES || len > max_len) begin
          pkt_expected.push_back('{8'h00, 1'b0, 1'b1});
        end else begin
          for (int k = 0; k < lppd_pkg::HDR_BYTES; k++)
            pkt_expected.push_back('{hdr_bytes[k],
                                     (k == lppd_pkg::HDR_BYTES - 1) &&
                                     (len == lppd_pkg::HDR_BYTES),
                                     1'b0});
          if (len > lppd_pkg::HDR_BYTES) begin
            in_body = 1'b1;
            body_left = lppd_pkg::LEN_W'(len - lppd_pkg::HDR_BYTES);
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pkt_beat_t want;
    if (!rst) begin
      if (rx.valid && rx.ready) deframe_byte(rx.func, rx.data_byte);
      if (pkt.valid && pkt.ready) begin
        if (pkt_expected.size() == 0) begin
          $error("unexpected beat: out_byte %0h last_in_packet %0b header_dropped %0b",
                 pkt.out_byte, pkt.last_in_packet, pkt.header_dropped);
          fail_count++;
        end else begin
          want = pkt_expected.pop_front();
          if (pkt.out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, pkt.out_byte);
            fail_count++;
          end
          if (pkt.last_in_packet !== want.last) begin
            $error("last_in_packet: expected %0b, got %0b", want.last, pkt.last_in_packet);
            fail_count++;
          end
          if (pkt.header_dropped !== want.dropped) begin
            $error("header_dropped: expected %0b, got %0b", want.dropped, pkt.header_dropped);
            fail_count++;
          end
        end
      end
    end
  end

  // The receiver switches between stall patterns and honors long hold-off requests.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rcv_cycle == 0) begin
      rcv_mode = rcv_mode_t'($urandom_range(0, 3));
      rcv_cycle = $urandom_range(20, 80);
    end else begin
      rcv_cycle--;
    end
    if (hold_left > 0) begin
      hold_left--;
      pkt.ready <= 1'b0;
    end else begin
      case (rcv_mode)
        RCV_STREAM: pkt.ready <= 1'b1;
        RCV_COIN:   pkt.ready <= 1'($urandom_range(0, 1));
        RCV_SPARSE: pkt.ready <= ($urandom_range(0, 3) == 0);
        default:    pkt.ready <= (rcv_cycle % 3 != 0);
      endcase
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rx.valid <= 1'b1;
    rx.func <= f;
    rx.data_byte <= b;
    do @(posedge clk); while (!rx.ready);
    burst_left--;
    items_sent++;
  endtask

  // Sends the first nbytes of a packet whose header carries len_field.
  task automatic send_packet(input logic [15:0] len_field, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0) send_item(FUNC_DATA, len_field[15:8]);
      else if (i == 1) send_item(FUNC_DATA, len_field[7:0]);
      else send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pkt_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [lppd_pkg::LEN_W-1:0] value);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    max_len = value;
  endtask

  task automatic test_header_rules();
    send_packet(16'd8, 8);
    send_packet(16'hFFFF, 8);
    send_packet(16'd20, 3);
    send_item(FUNC_CLOSE, 8'hFF);
    send_item(FUNC_CLOSE, 8'h00);
    wait_idle();
  endtask

  task automatic test_length_limits();
    write_max_len(16'd8);
    send_packet(16'd8, 8);
    send_packet(16'd9, 8);
    send_packet(16'd7, 8);
    write_max_len(16'd20);
    send_packet(16'd20, 20);
    send_packet(16'd21, 8);
    send_packet(16'd0, 8);
    write_max_len(16'hFFFF);
    send_packet(16'd12, 12);
    send_packet(16'd7, 8);
    send_packet(16'd264, 20);
    send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
    send_packet(16'd12, 10);
    send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
    send_packet(16'd9, 9);
    write_max_len(lppd_pkg::MAX_LEN_RESET);
  endtask

  task automatic test_backpressure();
    int len;
    wait_idle();
    hold_request = 300;
    for (int n = 0; n < 4; n++) begin
      len = $urandom_range(12, 16);
      send_packet(16'(len), len);
    end
    wait_idle();
  endtask

  task automatic test_random();
    int stop_at;
    int pick;
    int lim;
    int len;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) write_max_len(16'd8);
        else if (pick == 1) write_max_len(16'($urandom_range(8, 48)));
        else if (pick == 2) write_max_len(16'hFFFF);
        else write_max_len(lppd_pkg::MAX_LEN_RESET);
      end
      lim = (max_len < 40) ? int'(max_len) : 40;
      len = ($urandom_range(0, 6) == 0) ? lppd_pkg::HDR_BYTES :
            $urandom_range(lppd_pkg::HDR_BYTES, lim);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_packet(16'(len), len);
      end else if (pick < 72) begin
        if (max_len != 16'hFFFF && $urandom_range(0, 1) == 1)
          send_packet(16'($urandom_range(int'(max_len) + 1, 65535)), lppd_pkg::HDR_BYTES);
        else
          send_packet(16'($urandom_range(0, lppd_pkg::HDR_BYTES - 1)), lppd_pkg::HDR_BYTES);
      end else if (pick < 85) begin
        send_packet(16'(len), $urandom_range(1, len - 1));
        send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
        send_item(FUNC_CLOSE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.func = FUNC_DATA;
    rx.data_byte = 8'h00;
    pkt.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_header_rules();
    test_length_limits();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_length_prefixed_packet_deframer OK");
    end else begin
      $display("tb_length_prefixed_packet_deframer NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_length_prefixed_packet_deframer NOT OK");
    $finish;
  end

endmodule
